// ===== sv/rau_pkg.sv =====
package rau_pkg;

  localparam int MAG_W = 32;
  localparam int PROD_W = 64;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] x;
    logic [PROD_W-1:0] y;
  } gcd_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] g;
  } gcd_rsp_t;

endpackage

// ===== sv/rational_arithmetic_unit.sv =====
// Each item carries one operation on two signed fractions and gives one result item.
// The unit works on one item at a time and is not ready while it does so: it reduces
// each operand, forms the cross products on one shared 32x32 multiplier and then
// reduces the result. Each reduction of nonzero values runs a binary gcd and two
// 64-step restoring divisions on one shared divider. A finished result waits in the
// output register until it is taken; the next item may be accepted meanwhile, but it
// cannot finish before that result has gone.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // kind[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99]
  input  logic [135:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // res_num[31:0], res_den[62:32], less[63], equal[64], status[66:65]
  output logic [71:0] m_tdata
);

  localparam int EFF_W = (WIDTH > 32) ? 32 : ((WIDTH < 2) ? 2 : WIDTH);
  localparam logic [PROD_W-1:0] POS_MAX = (PROD_W'(1) << (EFF_W - 1)) - PROD_W'(1);
  localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(1) << (EFF_W - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED = 4'd1;
  localparam logic [3:0] S_GW = 4'd2;
  localparam logic [3:0] S_D1 = 4'd3;
  localparam logic [3:0] S_D2 = 4'd4;
  localparam logic [3:0] S_MUL = 4'd5;
  localparam logic [3:0] S_OP = 4'd6;
  localparam logic [3:0] S_OUT = 4'd7;

  logic [3:0] state;
  logic [1:0] phase;   // 0 reduce a, 1 reduce b, 2 reduce result
  logic [1:0] mstep;
  logic [2:0] kind;
  logic a_neg, b_neg, r_neg;
  logic [PROD_W-1:0] a_n, a_d, b_n, b_d, r_n, r_d, t1, t2;
  logic [PROD_W-1:0] cur_n, cur_d, g;
  logic [1:0] status;
  logic less_f, equal_f;

  logic [MAG_W-1:0] mul_x, mul_y;
  logic [PROD_W-1:0] mul_p;
  gcd_req_t greq;
  gcd_rsp_t grsp;
  logic dstart, ddone;
  logic [PROD_W-1:0] ddividend, ddivisor, dquot;

  rau_gcd u_gcd (.clk(clk), .rst(rst), .req(greq), .rsp(grsp));
  rau_div u_div (.clk(clk), .rst(rst), .start(dstart), .dividend(ddividend),
                 .divisor(ddivisor), .done(ddone), .quot(dquot));

  function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
    return v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);
  assign ddividend = (state == S_D1) ? cur_d : cur_n;
  assign ddivisor = (state == S_GW) ? grsp.g : g;

  always_comb begin
    unique case (mstep)
      2'd0: begin mul_x = a_n[MAG_W-1:0]; mul_y = b_d[MAG_W-1:0]; end
      2'd1: begin mul_x = b_n[MAG_W-1:0]; mul_y = a_d[MAG_W-1:0]; end
      2'd2: begin mul_x = a_d[MAG_W-1:0]; mul_y = b_d[MAG_W-1:0]; end
      default: begin
        mul_x = (kind == KIND_DIV) ? a_d[MAG_W-1:0] : a_n[MAG_W-1:0];
        mul_y = b_n[MAG_W-1:0];
      end
    endcase
  end

  always_comb begin
    greq.start = 1'b0;
    greq.x = cur_n;
    greq.y = cur_d;
    dstart = 1'b0;
    if (state == S_RED && cur_n != '0 && cur_d != '0) greq.start = 1'b1;
    if (state == S_GW && grsp.done) dstart = 1'b1;
    if (state == S_D1 && ddone) dstart = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind <= s_tdata[2:0];
            a_neg <= s_tdata[34] ^ s_tdata[66];
            b_neg <= s_tdata[98] ^ s_tdata[130];
            a_n <= PROD_W'(mag(s_tdata[34:3]));
            a_d <= PROD_W'(mag(s_tdata[66:35]));
            b_n <= PROD_W'(mag(s_tdata[98:67]));
            b_d <= PROD_W'(mag(s_tdata[130:99]));
            cur_n <= PROD_W'(mag(s_tdata[34:3]));
            cur_d <= PROD_W'(mag(s_tdata[66:35]));
            phase <= 2'd0;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (cur_n == '0 || cur_d == '0) begin
            cur_n <= '0;
            cur_d <= PROD_W'(1);
            state <= S_D2;
            g <= '0;
          end else begin
            state <= S_GW;
          end
        end
        S_GW: begin
          if (grsp.done) begin
            g <= grsp.g;
            state <= S_D1;
          end
        end
        S_D1: begin
          if (ddone) begin
            cur_n <= dquot;
            state <= S_D2;
          end
        end
        S_D2: begin
          if (g == '0 || ddone) begin
            if (g != '0) cur_d <= dquot;
            state <= S_OP;
            if (phase == 2'd0) begin
              if (g == '0) a_neg <= 1'b0;
              a_n <= cur_n;
              a_d <= (g == '0) ? cur_d : a_d;
            end else if (phase == 2'd1) begin
              if (g == '0) b_neg <= 1'b0;
              b_n <= cur_n;
              b_d <= (g == '0) ? cur_d : b_d;
            end else begin
              if (g == '0) r_neg <= 1'b0;
              r_n <= cur_n;
            end
          end
        end
        S_OP: begin
          if (phase == 2'd0) begin
            if (a_d != cur_d) a_d <= cur_d;
            cur_n <= b_n;
            cur_d <= b_d;
            phase <= 2'd1;
            state <= S_RED;
          end else if (phase == 2'd1) begin
            if (b_d != cur_d) b_d <= cur_d;
            mstep <= 2'd0;
            state <= S_MUL;
          end else begin
            r_d <= cur_d;
            state <= S_OUT;
          end
        end
        S_MUL: begin
          mstep <= mstep + 2'd1;
          unique case (mstep)
            2'd0: t1 <= mul_p;
            2'd1: t2 <= mul_p;
            2'd2: r_d <= mul_p;
            default: begin
              state <= S_RED;
              phase <= 2'd2;
              status <= ST_OK;
              begin
                logic s2;
                logic sa, sb;
                s2 = (kind == KIND_SUB) ? !b_neg : b_neg;
                sa = (t1 == '0) ? 1'b0 : a_neg;
                sb = (t2 == '0) ? 1'b0 : b_neg;
                if (sa != sb) begin
                  less_f <= sa;
                  equal_f <= 1'b0;
                end else begin
                  equal_f <= (t1 == t2);
                  less_f <= (t1 != t2) && (sa ? (t1 > t2) : (t1 < t2));
                end
                cur_n <= a_n;
                cur_d <= a_d;
                r_neg <= a_neg;
                if (kind == KIND_ADD || kind == KIND_SUB) begin
                  cur_d <= r_d;
                  if (a_neg == s2) begin
                    cur_n <= t1 + t2;
                  end else if (t1 >= t2) begin
                    cur_n <= t1 - t2;
                  end else begin
                    cur_n <= t2 - t1;
                    r_neg <= s2;
                  end
                end else if (kind == KIND_MUL) begin
                  cur_n <= mul_p;
                  cur_d <= r_d;
                  r_neg <= a_neg ^ b_neg;
                end else if (kind == KIND_DIV) begin
                  if (b_n == '0) begin
                    status <= ST_DIV0;
                  end else begin
                    cur_n <= t1;
                    cur_d <= mul_p;
                    r_neg <= a_neg ^ b_neg;
                  end
                end
              end
            end
          endcase
        end
        S_OUT: begin
          if (!m_tvalid) begin
            if (r_d > POS_MAX || r_n > (r_neg ? NEG_MAX : POS_MAX)) begin
              m_tdata <= {5'd0, ST_OVF, equal_f, less_f, 31'd1, 32'd0};
            end else begin
              m_tdata <= {5'd0, status, equal_f, less_f, r_d[30:0],
                          r_neg ? (32'd0 - r_n[31:0]) : r_n[31:0]};
            end
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready)
    else $error("input accepted while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[62:32] != 31'd0))
    else $error("zero denominator");
`endif

endmodule

// ===== sv/rau_gcd.sv =====
module rau_gcd
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  gcd_req_t req,
  output gcd_rsp_t rsp
);

  logic [PROD_W-1:0] x;
  logic [PROD_W-1:0] y;
  logic [6:0] shift;
  logic busy;
  logic [PROD_W-1:0] diff;

  // Binary gcd: one shift or one subtract-and-shift each cycle. Both operands must be nonzero.
  assign diff = (x > y) ? (x - y) : (y - x);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        x <= req.x;
        y <= req.y;
        shift <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (x == y) begin
          rsp.g <= x << shift;
          rsp.done <= 1'b1;
          busy <= 1'b0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          shift <= shift + 7'd1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x > y) begin
          x <= diff >> 1;
        end else begin
          y <= diff >> 1;
        end
      end
    end
  end

endmodule

// ===== sv/rau_div.sv =====
module rau_div
  import rau_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [PROD_W-1:0] divisor,
  output logic              done,
  output logic [PROD_W-1:0] quot
);

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] q;
  logic [PROD_W-1:0] dv;
  logic [6:0] cnt;
  logic busy;
  logic [PROD_W:0] trial;

  assign trial = {rem, q[PROD_W-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        q <= dividend;
        dv <= divisor;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!trial[PROD_W]) begin
          rem <= trial[PROD_W-1:0];
          q <= {q[PROD_W-2:0], 1'b1};
        end else begin
          rem <= {rem[PROD_W-2:0], q[PROD_W-1]};
          q <= {q[PROD_W-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule
